FILE: design/rdat_pkg.sv
package rdat_pkg;

  // Fixed field widths of the header and result words.
  localparam int SEQ_W   = 16;
  localparam int MAGIC_W = 32;
  localparam int ACK_W   = 32;
  localparam int OUT_H_W = 32;
  localparam int COUNT_W = 6;

  // Largest value the outstanding count can show.
  localparam int COUNT_MAX = 63;

  // Half of the sequence space: a forward distance up to this is newer.
  localparam logic [SEQ_W-1:0] HALF_SEQ = SEQ_W'(1 << (SEQ_W - 1));

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Operation chosen by the front for each accepted word.
  typedef enum logic [1:0] {
    OP_REJECT = 2'd0,
    OP_HEADER = 2'd1,
    OP_SEND   = 2'd2
  } op_e;

  // One classified word as it travels through the queue.
  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] rseq;
    logic [SEQ_W-1:0] ack;
    logic [ACK_W-1:0] ack_bits;
    logic [SEQ_W-1:0] sseq;
  } cmd_t;

endpackage

FILE: design/rdat_front.sv
module rdat_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rdat_pkg::MAGIC_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [rdat_pkg::MAGIC_W-1:0] peer_magic_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   remote_seq_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   peer_ack_i,
  input  logic [rdat_pkg::ACK_W-1:0]   peer_ack_bits_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   sent_seq_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output rdat_pkg::cmd_t               q_cmd_o
);
  import rdat_pkg::*;

  logic [MAGIC_W-1:0] magic_q;

  // The local magic register is written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (cfg_we_i) begin
      magic_q <= cfg_wdata_i;
    end
  end

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the word: a send, a header with matching magic, or a reject.
  always_comb begin
    q_cmd_o.rseq     = remote_seq_i;
    q_cmd_o.ack      = peer_ack_i;
    q_cmd_o.ack_bits = peer_ack_bits_i;
    q_cmd_o.sseq     = sent_seq_i;
    if (kind_i) begin
      q_cmd_o.op = OP_SEND;
    end else if (peer_magic_i == magic_q) begin
      q_cmd_o.op = OP_HEADER;
    end else begin
      q_cmd_o.op = OP_REJECT;
    end
  end

endmodule

FILE: design/rdat_queue.sv
module rdat_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rdat_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output rdat_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import rdat_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: design/rdat_back.sv
module rdat_back #(
  parameter int HISTORY_BITS = 32,
  parameter int SENT_ENTRIES = 32,
  parameter int MAX_AGE      = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  input  rdat_pkg::cmd_t               q_cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic [rdat_pkg::SEQ_W-1:0]   latest_received_o,
  output logic [rdat_pkg::OUT_H_W-1:0] received_history_o,
  output logic [rdat_pkg::COUNT_W-1:0] outstanding_count_o
);
  import rdat_pkg::*;

  localparam int IDX_W   = $clog2(SENT_ENTRIES);
  localparam int ACK_WIN = (HISTORY_BITS < ACK_W) ? HISTORY_BITS : ACK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENT_ENTRIES - 1);
  localparam logic [SEQ_W-1:0] AGE_LIMIT = SEQ_W'(MAX_AGE);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_REPORT = 3'b100
  } back_state_e;

  back_state_e             state_q, state_d;
  cmd_t                    cmd_q, cmd_d;
  logic [SENT_ENTRIES-1:0] valid_q, valid_d;
  logic [SEQ_W-1:0]        seq_q [SENT_ENTRIES];
  logic [SEQ_W-1:0]        highest_q, highest_d;
  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [SEQ_W-1:0]        best_age_q, best_age_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_acc_q, out_acc_d;
  logic [SEQ_W-1:0]        out_latest_q, out_latest_d;
  logic [OUT_H_W-1:0]      out_hist_q, out_hist_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;

  // Table write port.
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [SEQ_W-1:0]        wr_seq;

  // Per-entry compare results for the word at the head of the queue.
  logic [SENT_ENTRIES-1:0] ack_hit;
  logic [SENT_ENTRIES-1:0] keep;
  logic [SENT_ENTRIES-1:0] dup;
  logic                    free_any;
  logic [IDX_W-1:0]        free_idx;
  logic [SEQ_W-1:0]        scan_age;
  logic [IDX_W:0]          pop_cnt;
  logic [OUT_H_W-1:0]      hist_view;

  // One-hot history mask for a bit position, empty outside the window.
  function automatic logic [HISTORY_BITS-1:0] hist_bit(input logic [SEQ_W-1:0] pos);
    logic [HISTORY_BITS-1:0] v;
    for (int i = 0; i < HISTORY_BITS; i++) begin
      v[i] = (pos == SEQ_W'(i));
    end
    return v;
  endfunction

  // Every entry compares its sequence against the ack and the send sequence.
  always_comb begin
    logic [SEQ_W-1:0] back;
    logic [SEQ_W-1:0] back_m1;
    logic [SEQ_W-1:0] age;
    for (int i = 0; i < SENT_ENTRIES; i++) begin
      back       = q_cmd_i.ack - seq_q[i];
      back_m1    = back - 1'b1;
      ack_hit[i] = valid_q[i] && ((back == '0) ||
                   ((back_m1 < SEQ_W'(ACK_WIN)) && q_cmd_i.ack_bits[back_m1[4:0]]));
      age        = q_cmd_i.sseq - seq_q[i];
      keep[i]    = valid_q[i] && (age <= AGE_LIMIT);
      dup[i]     = keep[i] && (age == '0);
    end
  end

  // Lowest free slot once stale entries are dropped.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SENT_ENTRIES - 1; i >= 0; i--) begin
      if (!keep[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Number of valid entries, shown in the result word.
  always_comb begin
    pop_cnt = '0;
    for (int i = 0; i < SENT_ENTRIES; i++) begin
      pop_cnt = pop_cnt + {{IDX_W{1'b0}}, valid_q[i]};
    end
  end

  // Low part of the history as it appears in the result word.
  generate
    if (HISTORY_BITS >= OUT_H_W) begin : g_hist_wide
      assign hist_view = hist_q[OUT_H_W-1:0];
    end else begin : g_hist_narrow
      assign hist_view = {{(OUT_H_W - HISTORY_BITS){1'b0}}, hist_q};
    end
  endgenerate

  assign scan_age = cmd_q.sseq - seq_q[idx_q];

  // Sequencer: execute the word, scan for the oldest entry if needed, report.
  always_comb begin
    logic [SEQ_W-1:0] fwd;
    logic [SEQ_W-1:0] rev;
    fwd          = q_cmd_i.rseq - highest_q;
    rev          = highest_q - q_cmd_i.rseq;
    state_d      = state_q;
    cmd_d        = cmd_q;
    valid_d      = valid_q;
    highest_d    = highest_q;
    hist_d       = hist_q;
    idx_d        = idx_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_acc_d    = out_acc_q;
    out_latest_d = out_latest_q;
    out_hist_d   = out_hist_q;
    out_count_d  = out_count_q;
    q_pop_o      = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = free_idx;
    wr_seq       = q_cmd_i.sseq;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = ST_REPORT;
          case (q_cmd_i.op)
            OP_HEADER: begin
              valid_d = valid_q & ~ack_hit;
              if (fwd != '0) begin
                if (fwd <= HALF_SEQ) begin
                  hist_d    = (hist_q << fwd) | hist_bit(fwd - 1'b1);
                  highest_d = q_cmd_i.rseq;
                end else begin
                  hist_d = hist_q | hist_bit(rev - 1'b1);
                end
              end
            end
            OP_SEND: begin
              valid_d = keep;
              if (dup == '0) begin
                if (free_any) begin
                  valid_d[free_idx] = 1'b1;
                  wr_en             = 1'b1;
                end else begin
                  state_d    = ST_SCAN;
                  idx_d      = '0;
                  best_idx_d = '0;
                  best_age_d = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_age > best_age_q) begin
          best_age_d = scan_age;
          best_idx_d = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          wr_en   = 1'b1;
          wr_idx  = (scan_age > best_age_q) ? idx_q : best_idx_q;
          wr_seq  = cmd_q.sseq;
          state_d = ST_REPORT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_REPORT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_acc_d    = (cmd_q.op != OP_REJECT);
          out_latest_d = highest_q;
          out_hist_d   = hist_view;
          out_count_d  = (int'(pop_cnt) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                     : COUNT_W'(pop_cnt);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the receive window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      highest_q   <= '0;
      hist_q      <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      best_age_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      highest_q   <= highest_d;
      hist_q      <= hist_d;
      idx_q       <= idx_d;
      best_idx_q  <= best_idx_d;
      best_age_q  <= best_age_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: current word, result word and table sequences.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    out_acc_q    <= out_acc_d;
    out_latest_q <= out_latest_d;
    out_hist_q   <= out_hist_d;
    out_count_q  <= out_count_d;
    if (wr_en) begin
      seq_q[wr_idx] <= wr_seq;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_acc_q;
  assign latest_received_o   = out_latest_q;
  assign received_history_o  = out_hist_q;
  assign outstanding_count_o = out_count_q;

endmodule

FILE: design/reliable_datagram_ack_tracker.sv
// Acknowledgement tracker for a sequenced datagram link.
// Input channel (in_valid_i / in_stall_o): one word per received header
// (kind_i = 0) or per sent packet (kind_i = 1). A header whose magic equals
// the local magic clears the outstanding entries it acknowledges and updates
// the newest remote sequence and its history; a send records its sequence.
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word, in order, showing the state after that word.
// Configuration: cfg_we_i writes cfg_wdata_i into the local magic; write it
// only while no word is in flight.
// A word goes through the queue and then the back end's execute and report
// steps, which register the result; the back end finishes one word before it
// pops the next. A send that finds the table full with no stale or matching
// entry adds a scan of all SENT_ENTRIES entries to find the oldest. A two-word
// queue lets the input keep accepting while the back end works.
// Reset empties the table and clears the remote sequence, history and magic.
// While the receiver stalls, the result word holds; the back end then waits
// and the queue fills, after which in_stall_o rises.
module reliable_datagram_ack_tracker #(
  parameter int HISTORY_BITS = 32,
  parameter int SENT_ENTRIES = 32,
  parameter int MAX_AGE      = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rdat_pkg::MAGIC_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [rdat_pkg::MAGIC_W-1:0] peer_magic_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   remote_seq_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   peer_ack_i,
  input  logic [rdat_pkg::ACK_W-1:0]   peer_ack_bits_i,
  input  logic [rdat_pkg::SEQ_W-1:0]   sent_seq_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic [rdat_pkg::SEQ_W-1:0]   latest_received_o,
  output logic [rdat_pkg::OUT_H_W-1:0] received_history_o,
  output logic [rdat_pkg::COUNT_W-1:0] outstanding_count_o
);
  import rdat_pkg::*;

  logic q_full;
  logic q_push;
  logic q_empty;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Front: configuration register and classification.
  rdat_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .peer_magic_i    (peer_magic_i),
    .remote_seq_i    (remote_seq_i),
    .peer_ack_i      (peer_ack_i),
    .peer_ack_bits_i (peer_ack_bits_i),
    .sent_seq_i      (sent_seq_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  // Queue between front and back.
  rdat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  // Back: table, receive window and result register.
  rdat_back #(
    .HISTORY_BITS (HISTORY_BITS),
    .SENT_ENTRIES (SENT_ENTRIES),
    .MAX_AGE      (MAX_AGE)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_pop_o             (q_pop),
    .q_cmd_i             (head_cmd),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .accepted_o          (accepted_o),
    .latest_received_o   (latest_received_o),
    .received_history_o  (received_history_o),
    .outstanding_count_o (outstanding_count_o)
  );

endmodule
